// File: design/tasf_pkg.sv
package tasf_pkg;

   // token storage geometry
   localparam int TOKEN_SLOTS  = 8;
   localparam int TOKEN_BUFFER = 32;
   localparam int TOK_MAX      = TOKEN_BUFFER - 1;
   localparam int SLOT_W       = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
   localparam int COUNT_W      = $clog2(TOKEN_SLOTS + 1);
   localparam int LEN_W        = $clog2(TOKEN_BUFFER);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command and result kind codes
   localparam logic CMD_QUERY    = 1'b0;
   localparam logic CMD_NAME     = 1'b1;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      CLS_CHAR,
      CLS_SPACE,
      CLS_ZERO
   } class_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] text_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       matched;
      logic [3:0] token_count;
      logic       token_too_long;
   } rsp_type;

   // classified request as it travels through the queue
   typedef struct packed {
      logic       cmd;
      class_type  cls;
      logic [7:0] text_byte;
      logic       last;
   } item_type;

endpackage

// File: design/tasf_front.sv
module tasf_front (
   input  tasf_pkg::req_type  req_data,
   output tasf_pkg::item_type item
);

   logic is_lower;
   logic is_space;

   always_comb begin
      is_lower = (req_data.text_byte >= tasf_pkg::LOWER_A) &&
                 (req_data.text_byte <= tasf_pkg::LOWER_Z);
      is_space = (req_data.text_byte == tasf_pkg::CHAR_SPACE) ||
                 ((req_data.text_byte >= tasf_pkg::CHAR_TAB) &&
                  (req_data.text_byte <= tasf_pkg::CHAR_CR));

      item.cmd  = req_data.cmd;
      item.last = req_data.last;

      if (req_data.text_byte == tasf_pkg::CHAR_NUL) begin
         item.cls = tasf_pkg::CLS_ZERO;
      end else if (is_space) begin
         item.cls = tasf_pkg::CLS_SPACE;
      end else begin
         item.cls = tasf_pkg::CLS_CHAR;
      end

      // only query text is folded to upper case
      if ((req_data.cmd == tasf_pkg::CMD_QUERY) && is_lower) begin
         item.text_byte = req_data.text_byte - tasf_pkg::CASE_BIT;
      end else begin
         item.text_byte = req_data.text_byte;
      end
   end

endmodule

// File: design/tasf_queue.sv
module tasf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tasf_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tasf_pkg::item_type pop_item
);

   tasf_pkg::item_type mem_ff [tasf_pkg::QUEUE_DEPTH];

   logic [tasf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tasf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tasf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != tasf_pkg::QCNT_W'(tasf_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == tasf_pkg::QPTR_W'(tasf_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == tasf_pkg::QPTR_W'(tasf_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/tasf_back.sv
module tasf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  tasf_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tasf_pkg::rsp_type  rsp_data
);

   // query parse state
   logic [tasf_pkg::COUNT_W-1:0] held_ff, held_in;
   logic                         failed_ff, failed_in;
   logic                         qclosed_ff, qclosed_in;
   logic                         qactive_ff, qactive_in;
   logic                         in_tok_ff, in_tok_in;
   logic [tasf_pkg::LEN_W-1:0]   blen_ff, blen_in;

   // token store, compared in parallel at every position
   logic [7:0]                 text_ff [tasf_pkg::TOKEN_SLOTS][tasf_pkg::TOK_MAX];
   logic [tasf_pkg::LEN_W-1:0] len_ff  [tasf_pkg::TOKEN_SLOTS];

   // name match state
   logic [tasf_pkg::TOK_MAX-1:0]     prog_ff [tasf_pkg::TOKEN_SLOTS];
   logic [tasf_pkg::TOK_MAX-1:0]     prog_in [tasf_pkg::TOKEN_SLOTS];
   logic [tasf_pkg::TOKEN_SLOTS-1:0] found_ff, found_in;
   logic                             nclosed_ff, nclosed_in;
   logic                             nactive_ff, nactive_in;

   logic              rsp_valid_ff, rsp_valid_in;
   tasf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // per-token shift-and step
   logic [tasf_pkg::TOK_MAX-1:0]     step_base [tasf_pkg::TOKEN_SLOTS];
   logic [tasf_pkg::TOK_MAX-1:0]     step_nxt  [tasf_pkg::TOKEN_SLOTS];
   logic [tasf_pkg::TOKEN_SLOTS-1:0] step_hit;
   logic [tasf_pkg::TOKEN_SLOTS-1:0] slot_live;

   logic                         go;
   logic                         commit_req;
   logic [tasf_pkg::LEN_W-1:0]   blen_eff;
   logic                         txt_we;
   logic [tasf_pkg::SLOT_W-1:0]  txt_slot;
   logic [tasf_pkg::LEN_W-1:0]   txt_pos;
   logic                         len_we;
   logic [tasf_pkg::SLOT_W-1:0]  len_slot;
   logic [tasf_pkg::LEN_W-1:0]   len_data;

   assign item_ready = !item.last || !rsp_valid_ff || rsp_ready;
   assign go         = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
         slot_live[t] = (tasf_pkg::COUNT_W'(t) < held_ff);
         // a new name starts from cleared progress
         step_base[t] = ((nactive_ff ? prog_ff[t] : '0) << 1) | tasf_pkg::TOK_MAX'(1);
         step_hit[t]  = 1'b0;
         for (int i = 0; i < tasf_pkg::TOK_MAX; i++) begin
            step_nxt[t][i] = step_base[t][i] && (text_ff[t][i] == item.text_byte) &&
                             (tasf_pkg::LEN_W'(i) < len_ff[t]);
            if (step_nxt[t][i] && (tasf_pkg::LEN_W'(i + 1) == len_ff[t])) begin
               step_hit[t] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      held_in      = held_ff;
      failed_in    = failed_ff;
      qclosed_in   = qclosed_ff;
      qactive_in   = qactive_ff;
      in_tok_in    = in_tok_ff;
      blen_in      = blen_ff;
      prog_in      = prog_ff;
      found_in     = found_ff;
      nclosed_in   = nclosed_ff;
      nactive_in   = nactive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      commit_req   = 1'b0;
      blen_eff     = '0;
      txt_we       = 1'b0;
      txt_slot     = held_ff[tasf_pkg::SLOT_W-1:0];
      txt_pos      = '0;
      len_we       = 1'b0;
      len_slot     = held_ff[tasf_pkg::SLOT_W-1:0];
      len_data     = blen_ff;

      if (go) begin
         if (item.cmd == tasf_pkg::CMD_QUERY) begin
            if (!qactive_ff) begin
               // new query: drop tokens and any name in progress
               qactive_in = 1'b1;
               qclosed_in = 1'b0;
               failed_in  = 1'b0;
               held_in    = '0;
               in_tok_in  = 1'b0;
               blen_in    = '0;
               for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
                  prog_in[t] = '0;
               end
               found_in   = '0;
               nclosed_in = 1'b0;
               nactive_in = 1'b0;
            end
            if (!qclosed_in) begin
               case (item.cls)
                  tasf_pkg::CLS_CHAR: begin
                     blen_eff = in_tok_in ? blen_in : '0;
                     if (blen_eff >= tasf_pkg::LEN_W'(tasf_pkg::TOK_MAX)) begin
                        failed_in  = 1'b1;
                        qclosed_in = 1'b1;
                        in_tok_in  = 1'b0;
                     end else begin
                        txt_we    = 1'b1;
                        txt_slot  = held_in[tasf_pkg::SLOT_W-1:0];
                        txt_pos   = blen_eff;
                        in_tok_in = 1'b1;
                        blen_in   = blen_eff + 1'b1;
                     end
                  end
                  tasf_pkg::CLS_SPACE: begin
                     commit_req = 1'b1;
                  end
                  tasf_pkg::CLS_ZERO: begin
                     commit_req = 1'b1;
                     qclosed_in = 1'b1;
                  end
                  default: begin
                     commit_req = 1'b0;
                  end
               endcase
            end
            if (item.last) begin
               commit_req = 1'b1;
               qactive_in = 1'b0;
               qclosed_in = 1'b1;
            end
            if (commit_req) begin
               if (in_tok_in && (held_in < tasf_pkg::COUNT_W'(tasf_pkg::TOKEN_SLOTS))) begin
                  len_we   = 1'b1;
                  len_slot = held_in[tasf_pkg::SLOT_W-1:0];
                  len_data = blen_in;
                  held_in  = held_in + 1'b1;
                  if (held_in == tasf_pkg::COUNT_W'(tasf_pkg::TOKEN_SLOTS)) begin
                     qclosed_in = 1'b1;
                  end
               end
               in_tok_in = 1'b0;
               blen_in   = '0;
            end
         end else begin
            if (!nactive_ff) begin
               for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
                  prog_in[t] = '0;
               end
               found_in   = '0;
               nclosed_in = 1'b0;
               nactive_in = 1'b1;
            end
            if (!nclosed_in) begin
               if (item.cls == tasf_pkg::CLS_ZERO) begin
                  nclosed_in = 1'b1;
               end else begin
                  for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
                     if (slot_live[t]) begin
                        prog_in[t] = step_nxt[t];
                        if (step_hit[t]) begin
                           found_in[t] = 1'b1;
                        end
                     end
                  end
               end
            end
            if (item.last) begin
               nactive_in = 1'b0;
               nclosed_in = 1'b1;
            end
         end

         if (item.last) begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.kind           = (item.cmd == tasf_pkg::CMD_NAME) ?
                                         tasf_pkg::KIND_VERDICT : tasf_pkg::KIND_SUMMARY;
            rsp_data_in.token_count    = failed_in ? 4'd0 : 4'(held_in);
            rsp_data_in.token_too_long = failed_in;
            rsp_data_in.matched        = (item.cmd == tasf_pkg::CMD_NAME) && !failed_in &&
                                         (held_in != '0) && (&(found_in | ~slot_live));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         failed_ff    <= 1'b0;
         qclosed_ff   <= 1'b0;
         qactive_ff   <= 1'b0;
         in_tok_ff    <= 1'b0;
         blen_ff      <= '0;
         for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
            prog_ff[t] <= '0;
         end
         found_ff     <= '0;
         nclosed_ff   <= 1'b0;
         nactive_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         failed_ff    <= failed_in;
         qclosed_ff   <= qclosed_in;
         qactive_ff   <= qactive_in;
         in_tok_ff    <= in_tok_in;
         blen_ff      <= blen_in;
         prog_ff      <= prog_in;
         found_ff     <= found_in;
         nclosed_ff   <= nclosed_in;
         nactive_ff   <= nactive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int t = 0; t < tasf_pkg::TOKEN_SLOTS; t++) begin
         for (int i = 0; i < tasf_pkg::TOK_MAX; i++) begin
            if (txt_we && (txt_slot == tasf_pkg::SLOT_W'(t)) &&
                (txt_pos == tasf_pkg::LEN_W'(i))) begin
               text_ff[t][i] <= item.text_byte;
            end
         end
         if (len_we && (len_slot == tasf_pkg::SLOT_W'(t))) begin
            len_ff[t] <= len_data;
         end
      end
   end

endmodule

// File: design/token_and_substring_filter.sv
// path: a request carrying last is written into the queue, then read by the back end, which
// registers its result in the result register before it can be taken
// throughput: one request per cycle unless the back end holds off a last byte behind an untaken
// result; parse and shift-and update step every token slot at every position in parallel
// reset: synchronous active high; clears parse, match, queue and output state,
// token text and token lengths stay undefined until a query writes them
module token_and_substring_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tasf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tasf_pkg::rsp_type rsp_data
);

   // classified request entering the queue
   tasf_pkg::item_type front_item;

   // head of the queue as seen by the back end
   tasf_pkg::item_type back_item;
   logic               back_valid;
   logic               back_ready;

   // front end: whitespace / terminator classification and query case folding
   tasf_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   // short queue so front and back stall independently;
   // request is taken whenever the queue has room
   tasf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // back end: tokenizer state, token store, per-token shift-and matchers and
   // the result register; it only holds off on a last byte while a result waits
   tasf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
